// ===== hdl/bf16_multiplier_macros.svh =====
// assertion helpers for the bf16 multiplier
`ifndef BF16_MULTIPLIER_MACROS_SVH
`define BF16_MULTIPLIER_MACROS_SVH

// a property checked on every rising clock edge outside reset
`define BF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// an implication checked on every rising clock edge outside reset
`define BF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/bfm_pkg.sv =====
package bfm_pkg;

  localparam int unsigned BfBias = 127;
  localparam logic [15:0] BfQnan = 16'h7FC0;
  localparam int unsigned ExpW = 11;
  localparam int unsigned NumStages = 3;

  typedef enum logic [1:0] {
    SPECIAL_NONE = 2'd0,
    SPECIAL_NAN  = 2'd1,
    SPECIAL_ZERO = 2'd2,
    SPECIAL_INF  = 2'd3
  } special_e;

  typedef struct packed {
    logic                   sign;
    special_e               special;
    logic signed [ExpW-1:0] exp;
    logic [7:0]             ma;
    logic [7:0]             mb;
  } unpack_t;

  typedef struct packed {
    logic                   sign;
    special_e               special;
    logic signed [ExpW-1:0] exp;
    logic [15:0]            prod;
  } mult_t;

  // leading zero count of an 8-bit significand, 8 when zero
  function automatic logic [3:0] lzc8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) begin
        n = 4'(7 - i);
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/bfm_unpack.sv =====
module bfm_unpack
  import bfm_pkg::*;
(
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output unpack_t     unp_o
);

  logic [7:0] ea, eb;
  logic [6:0] fa, fb;
  logic       za, zb, nana, nanb, infa, infb;
  logic [3:0] sha, shb;
  logic [7:0] sfa, sfb;
  logic signed [ExpW-1:0] xa, xb;

  always_comb begin
    ea = operand_a_i[14:7];
    eb = operand_b_i[14:7];
    fa = operand_a_i[6:0];
    fb = operand_b_i[6:0];
    za = (ea == 8'd0) && (fa == 7'd0);
    zb = (eb == 8'd0) && (fb == 7'd0);
    nana = (ea == 8'hFF) && (fa != 7'd0);
    nanb = (eb == 8'hFF) && (fb != 7'd0);
    infa = (ea == 8'hFF) && (fa == 7'd0);
    infb = (eb == 8'hFF) && (fb == 7'd0);
    sfa = {1'b0, fa};
    sfb = {1'b0, fb};
    sha = lzc8(sfa);
    shb = lzc8(sfb);
    if (ea == 8'd0) begin
      xa = ExpW'(1) - ExpW'(sha);
      unp_o.ma = sfa << sha;
    end else begin
      xa = ExpW'(ea);
      unp_o.ma = {1'b1, fa};
    end
    if (eb == 8'd0) begin
      xb = ExpW'(1) - ExpW'(shb);
      unp_o.mb = sfb << shb;
    end else begin
      xb = ExpW'(eb);
      unp_o.mb = {1'b1, fb};
    end
    unp_o.sign = operand_a_i[15] ^ operand_b_i[15];
    unp_o.exp = xa + xb - ExpW'(BfBias);
    if (nana || nanb || (infa && zb) || (infb && za)) begin
      unp_o.special = SPECIAL_NAN;
    end else if (za || zb) begin
      unp_o.special = SPECIAL_ZERO;
    end else if (infa || infb) begin
      unp_o.special = SPECIAL_INF;
    end else begin
      unp_o.special = SPECIAL_NONE;
    end
  end

endmodule

// ===== hdl/bfm_round.sv =====
module bfm_round
  import bfm_pkg::*;
(
  input  mult_t       mul_i,
  output logic [15:0] product_o
);

  logic signed [ExpW-1:0] e;
  logic [7:0]  mant;
  logic [7:0]  low;
  logic        up;
  logic [8:0]  mr;
  logic [3:0]  sh;
  logic [7:0]  sig, sig_sh, mask;
  logic        rbit, sticky;
  logic [8:0]  sr;

  always_comb begin
    e = mul_i.exp;
    if (mul_i.prod[15]) begin
      e = e + ExpW'(1);
      mant = mul_i.prod[15:8];
      low = mul_i.prod[7:0];
      up = (low > 8'h80) || ((low == 8'h80) && mant[0]);
    end else begin
      mant = mul_i.prod[14:7];
      low = {1'b0, mul_i.prod[6:0]};
      up = (low > 8'h40) || ((low == 8'h40) && mant[0]);
    end
    mr = {1'b0, mant} + 9'(up);
    if (mr[8]) begin
      mr = mr >> 1;
      e = e + ExpW'(1);
    end
    sig = {1'b1, mr[6:0]};
    sh = 4'((ExpW'(1) - e) & ExpW'(15));
    mask = 8'((9'd1 << (sh - 4'd1)) - 9'd1);
    rbit = sig[3'(sh - 4'd1)];
    sticky = (sig & mask) != 8'd0;
    sig_sh = sig >> sh;
    sr = {1'b0, sig_sh} + 9'(rbit && (sticky || sig_sh[0]));
    case (mul_i.special)
      SPECIAL_NAN:  product_o = BfQnan;
      SPECIAL_ZERO: product_o = {mul_i.sign, 15'd0};
      SPECIAL_INF:  product_o = {mul_i.sign, 8'hFF, 7'd0};
      default: begin
        if (e < ExpW'(-6)) begin
          product_o = {mul_i.sign, 15'd0};
        end else if (e <= ExpW'(0)) begin
          product_o = {mul_i.sign, 7'd0, sr[7:0]};
        end else if (e >= ExpW'(255)) begin
          product_o = {mul_i.sign, 8'hFF, 7'd0};
        end else begin
          product_o = {mul_i.sign, e[7:0], mr[6:0]};
        end
      end
    endcase
  end

endmodule

// ===== hdl/bf16_multiplier.sv =====
// Pipelined bfloat16 multiplier. One operand pair is taken every cycle (busy_o is
// always low) and its product appears with done_o high for one cycle, after
// passing through the unpack, 8x8 multiply and round stages in that order.
// The receiver cannot stall; products must be taken when done_o is high.
// NaN results are the canonical 0x7FC0; subnormal inputs are supported.
`include "bf16_multiplier_macros.svh"
module bf16_multiplier
  import bfm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] operand_a_i,
  input  logic [15:0] operand_b_i,
  output logic        done_o,
  output logic [15:0] product_o
);

  unpack_t     unp_d, unp_q;
  mult_t       mul_d, mul_q;
  logic [15:0] prod_d, prod_q;
  logic [NumStages-1:0] vld_q;

  bfm_unpack u_unpack (
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .unp_o      (unp_d)
  );

  always_comb begin
    mul_d.sign    = unp_q.sign;
    mul_d.special = unp_q.special;
    mul_d.exp     = unp_q.exp;
    mul_d.prod    = unp_q.ma * unp_q.mb;
  end

  bfm_round u_round (
    .mul_i    (mul_q),
    .product_o(prod_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NumStages-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    unp_q  <= unp_d;
    mul_q  <= mul_d;
    prod_q <= prod_d;
  end

  assign busy_o    = 1'b0;
  assign done_o    = vld_q[NumStages-1];
  assign product_o = prod_q;

  `BF_ASSERT_IMP(a_latency, start_i, ##3 done_o, "request lost in pipeline")
  `BF_ASSERT_IMP(a_no_extra, done_o, $past(start_i, 3), "result without request")
  `BF_ASSERT_IMP(a_nan_canon, done_o && product_o[14:7] == 8'hFF && product_o[6:0] != 7'd0,
    product_o == BfQnan, "non-canonical nan")
  `BF_ASSERT(a_never_busy, !busy_o, "busy raised")

endmodule

// ===== verif/bf16_multiplier_tb.sv =====
`timescale 1ns / 100ps
module bf16_multiplier_tb
  import bfm_pkg::*;
;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [15:0] operand_a_i = '0;
  logic [15:0] operand_b_i = '0;
  logic        done_o;
  logic [15:0] product_o;

  logic [15:0] pending_products[$];
  int          error_count = 0;
  int          request_count = 0;
  int          product_count = 0;

  typedef struct {
    logic [15:0] a;
    logic [15:0] b;
    logic        known;
    logic [15:0] product;
  } bf_row_t;

  bf16_multiplier u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .operand_a_i(operand_a_i),
    .operand_b_i(operand_b_i),
    .done_o     (done_o),
    .product_o  (product_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [15:0] bf_mul(input logic [15:0] a, input logic [15:0] b);
    logic        sgn;
    logic [7:0]  ea, eb;
    logic [6:0]  fa, fb;
    logic        za, zb;
    int          xa, xb, ex, drop, sh;
    logic [7:0]  ma, mb, sig;
    logic [15:0] prod, low, half;
    logic [8:0]  mant;
    logic        rbit, sticky;
    sgn = a[15] ^ b[15];
    ea = a[14:7];
    eb = b[14:7];
    fa = a[6:0];
    fb = b[6:0];
    za = (ea == 8'h00) && (fa == 7'd0);
    zb = (eb == 8'h00) && (fb == 7'd0);
    if ((ea == 8'hFF && fa != 0) || (eb == 8'hFF && fb != 0)) return BfQnan;
    if ((ea == 8'hFF && zb) || (eb == 8'hFF && za)) return BfQnan;
    if (za || zb) return {sgn, 15'd0};
    if (ea == 8'hFF || eb == 8'hFF) return {sgn, 8'hFF, 7'd0};
    if (ea == 0) begin
      ma = {1'b0, fa};
      xa = 1;
      while (!ma[7]) begin
        ma = ma << 1;
        xa--;
      end
    end else begin
      ma = {1'b1, fa};
      xa = ea;
    end
    if (eb == 0) begin
      mb = {1'b0, fb};
      xb = 1;
      while (!mb[7]) begin
        mb = mb << 1;
        xb--;
      end
    end else begin
      mb = {1'b1, fb};
      xb = eb;
    end
    ex = xa + xb - int'(BfBias);
    prod = ma * mb;
    if (prod[15]) begin
      ex++;
      drop = 8;
      half = 16'h80;
    end else begin
      drop = 7;
      half = 16'h40;
    end
    low = prod & ((16'd1 << drop) - 16'd1);
    mant = 9'(prod >> drop);
    if (low > half || (low == half && mant[0])) begin
      mant++;
      if (mant[8]) begin
        mant = mant >> 1;
        ex++;
      end
    end
    if (ex <= 0) begin
      if (ex < -6) return {sgn, 15'd0};
      sig = {1'b1, mant[6:0]};
      sh = 1 - ex;
      rbit = sig[sh-1];
      sticky = (sig & ((8'd1 << (sh - 1)) - 8'd1)) != 0;
      sig = sig >> sh;
      if (rbit && (sticky || sig[0])) sig++;
      return {sgn, 7'd0, sig};
    end
    if (ex >= 255) return {sgn, 8'hFF, 7'd0};
    return {sgn, 8'(ex), mant[6:0]};
  endfunction

  task automatic send_request(input logic [15:0] a, input logic [15:0] b,
                              input logic known, input logic [15:0] want);
    logic [15:0] model;
    model = bf_mul(a, b);
    if (known && model !== want) begin
      $error("table product a=%h b=%h expected %h predicted %h", a, b, want, model);
      error_count++;
    end
    start_i <= 1'b1;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    pending_products.insert(pending_products.size(), model);
    request_count++;
    @(negedge clk_i);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic logic [15:0] rand_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v[14:7] = 8'h00;
      1: v[14:7] = 8'hFF;
      2: v[14:7] = 8'($urandom_range(1, 8));
      3: v[14:7] = 8'($urandom_range(247, 254));
      4: v[14:0] = 15'd0;
      default: v[14:7] = 8'($urandom_range(40, 214));
    endcase
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_products.size() == 0) begin
        $error("product %h with none expected", product_o);
        error_count++;
      end else begin
        if (product_o !== pending_products[0]) begin
          $error("product expected %h actual %h", pending_products[0], product_o);
          error_count++;
        end
        pending_products.delete(0);
        product_count++;
      end
    end
  end

  initial begin
    bf_row_t rows[$];
    logic [15:0] a, b;
    int wait_cycles;
    rows = '{
      '{16'h3F80, 16'h3F80, 1'b1, 16'h3F80},
      '{16'hBF80, 16'h3F80, 1'b1, 16'hBF80},
      '{16'h0000, 16'h8000, 1'b1, 16'h8000},
      '{16'h0000, 16'h4000, 1'b1, 16'h0000},
      '{16'h7F80, 16'h0000, 1'b1, 16'h7FC0},
      '{16'h8000, 16'hFF80, 1'b1, 16'h7FC0},
      '{16'h7FC1, 16'h3F80, 1'b1, 16'h7FC0},
      '{16'h3F80, 16'hFFFF, 1'b1, 16'h7FC0},
      '{16'h7F80, 16'hBF80, 1'b1, 16'hFF80},
      '{16'hFF80, 16'hFF80, 1'b1, 16'h7F80},
      '{16'h7F7F, 16'h7F7F, 1'b1, 16'h7F80},
      '{16'h0001, 16'h0001, 1'b1, 16'h0000},
      '{16'h0001, 16'h3F80, 1'b1, 16'h0001},
      '{16'h007F, 16'h3F80, 1'b0, 16'h0000},
      '{16'h0080, 16'h3F00, 1'b0, 16'h0000},
      '{16'h00FF, 16'h3F00, 1'b0, 16'h0000},
      '{16'h0081, 16'h3EFF, 1'b0, 16'h0000},
      '{16'h3FFF, 16'h3FFF, 1'b0, 16'h0000},
      '{16'h0040, 16'h4200, 1'b0, 16'h0000},
      '{16'h1FFF, 16'h1FFF, 1'b0, 16'h0000},
      '{16'h2000, 16'h1F80, 1'b0, 16'h0000},
      '{16'hFFFF, 16'h0000, 1'b1, 16'h7FC0},
      '{16'hFF7F, 16'h7F7F, 1'b1, 16'hFF80}
    };
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_request(rows[i].a, rows[i].b, rows[i].known, rows[i].product);
    for (int i = 0; i < 1600; i++) begin
      idle_gap();
      a = rand_operand();
      b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : rand_operand();
      send_request(a, b, 1'b0, 16'h0000);
    end
    start_i <= 1'b0;
    wait_cycles = 0;
    while (pending_products.size() != 0 && wait_cycles < 1000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (10) @(negedge clk_i);
    $display("sent %0d operand pairs (table plus random), checked %0d products",
             request_count, product_count);
    if (error_count == 0 && pending_products.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/bfm_pkg.sv
hdl/bfm_unpack.sv
hdl/bfm_round.sv
hdl/bf16_multiplier.sv
verif/bf16_multiplier_tb.sv
